[hw/rtl/stm_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// stm_pkg
// Types and constants shared by the sorted tuple merge unit.
// ---------------------------------------------------------------------------
package stm_pkg;

   localparam int KEY_BITS     = 32;
   localparam int PAYLOAD_BITS = 32;

   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // input kinds
   localparam logic [1:0] KIND_A_ELEM = 2'd0;
   localparam logic [1:0] KIND_B_ELEM = 2'd1;
   localparam logic [1:0] KIND_A_END  = 2'd2;
   localparam logic [1:0] KIND_B_END  = 2'd3;

   // list request codes
   localparam logic [1:0] WANT_A    = 2'd0;
   localparam logic [1:0] WANT_B    = 2'd1;
   localparam logic [1:0] WANT_NONE = 2'd2;

   typedef struct packed {
      logic [1:0]                     kind;
      logic signed [KEY_BITS-1:0]     key;
      logic [PAYLOAD_BITS-1:0]        payload;
   } req_type;

   typedef struct packed {
      logic                           out_valid;
      logic signed [KEY_BITS-1:0]     out_key;
      logic [PAYLOAD_BITS-1:0]        out_payload;
      logic                           from_list_b;
      logic [1:0]                     want_next;
      logic                           done_res;
      logic                           error;
   } rsp_type;

   // classified item as held in the queue
   typedef struct packed {
      logic                           is_b;
      logic                           is_end;
      logic signed [KEY_BITS-1:0]     key;
      logic [PAYLOAD_BITS-1:0]        payload;
   } item_type;

   // front -> queue push
   typedef struct packed {
      logic     push;
      item_type item;
   } push_type;

   // queue -> back head of queue
   typedef struct packed {
      logic     avail;
      item_type item;
   } head_type;

endpackage
`default_nettype wire

[hw/rtl/stm_queue.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// stm_queue
// Short FIFO of classified items between the front and back parts.
// ---------------------------------------------------------------------------
module stm_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire stm_pkg::push_type  wr,
   output logic                    full,
   input  wire logic               pop,
   output stm_pkg::head_type       rd
);

   stm_pkg::item_type entry_ff [stm_pkg::QUEUE_DEPTH];

   logic [stm_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [stm_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [stm_pkg::QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic                               do_wr, do_rd;

   localparam logic [stm_pkg::QUEUE_PTR_BITS-1:0] LAST_PTR =
      stm_pkg::QUEUE_PTR_BITS'(stm_pkg::QUEUE_DEPTH - 1);
   localparam logic [stm_pkg::QUEUE_CNT_BITS-1:0] FULL_CNT =
      stm_pkg::QUEUE_CNT_BITS'(stm_pkg::QUEUE_DEPTH);

   assign full     = (count_ff == FULL_CNT);
   assign rd.avail = (count_ff != '0);
   assign rd.item  = entry_ff[rd_ptr_ff];

   assign do_wr = wr.push && !full;
   assign do_rd = pop && rd.avail;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr.item;
      end
   end

endmodule
`default_nettype wire

[hw/rtl/stm_front.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// stm_front
// Accepts request beats, splits the kind into list and end flags and
// pushes the classified item into the queue.
// ---------------------------------------------------------------------------
module stm_front (
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire stm_pkg::req_type  req_data,
   input  wire logic              queue_full,
   output stm_pkg::push_type      wr
);

   always_comb begin
      wr.push         = req_valid && !queue_full;
      wr.item.key     = req_data.key;
      wr.item.payload = req_data.payload;
      case (req_data.kind)
         stm_pkg::KIND_A_ELEM: begin
            wr.item.is_b   = 1'b0;
            wr.item.is_end = 1'b0;
         end
         stm_pkg::KIND_B_ELEM: begin
            wr.item.is_b   = 1'b1;
            wr.item.is_end = 1'b0;
         end
         stm_pkg::KIND_A_END: begin
            wr.item.is_b   = 1'b0;
            wr.item.is_end = 1'b1;
         end
         stm_pkg::KIND_B_END: begin
            wr.item.is_b   = 1'b1;
            wr.item.is_end = 1'b1;
         end
         default: begin
            wr.item.is_b   = 1'b0;
            wr.item.is_end = 1'b0;
         end
      endcase
   end

   assign req_stall = queue_full;

endmodule
`default_nettype wire

[hw/rtl/stm_back.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// stm_back
// Merge core: holds both list heads, compares them, picks the tuple to
// emit and registers one response beat per queued item.
// ---------------------------------------------------------------------------
module stm_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire stm_pkg::head_type  rd,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output stm_pkg::rsp_type        rsp_data
);

   logic signed [stm_pkg::KEY_BITS-1:0] a_key_ff, a_key_in, b_key_ff, b_key_in;
   logic [stm_pkg::PAYLOAD_BITS-1:0]    a_pay_ff, a_pay_in, b_pay_ff, b_pay_in;
   logic a_full_ff, a_full_in, b_full_ff, b_full_in;
   logic a_fin_ff, a_fin_in, b_fin_ff, b_fin_in;

   logic             rsp_valid_ff, rsp_valid_in;
   stm_pkg::rsp_type rsp_ff, rsp_in;

   logic [1:0] want_now, want_after;
   logic       na_full, nb_full, na_fin, nb_fin;
   logic       take_a, take_b;

   assign pop = rd.avail && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      if (!a_full_ff && !a_fin_ff) begin
         want_now = stm_pkg::WANT_A;
      end else if (!b_full_ff && !b_fin_ff) begin
         want_now = stm_pkg::WANT_B;
      end else begin
         want_now = stm_pkg::WANT_NONE;
      end
   end

   always_comb begin
      a_key_in = a_key_ff;
      a_pay_in = a_pay_ff;
      b_key_in = b_key_ff;
      b_pay_in = b_pay_ff;
      na_full  = a_full_ff;
      nb_full  = b_full_ff;
      na_fin   = a_fin_ff;
      nb_fin   = b_fin_ff;

      if (!rd.item.is_end && !rd.item.is_b) begin
         a_key_in = rd.item.key;
         a_pay_in = rd.item.payload;
         na_full  = 1'b1;
      end
      if (!rd.item.is_end && rd.item.is_b) begin
         b_key_in = rd.item.key;
         b_pay_in = rd.item.payload;
         nb_full  = 1'b1;
      end
      if (rd.item.is_end && !rd.item.is_b) begin
         na_fin = 1'b1;
      end
      if (rd.item.is_end && rd.item.is_b) begin
         nb_fin = 1'b1;
      end

      // equal keys favor B
      take_a = 1'b0;
      take_b = 1'b0;
      if (na_full && nb_full) begin
         take_a = (a_key_in < b_key_in);
         take_b = !(a_key_in < b_key_in);
      end else if (na_full && nb_fin) begin
         take_a = 1'b1;
      end else if (nb_full && na_fin) begin
         take_b = 1'b1;
      end

      a_full_in = na_full && !take_a;
      b_full_in = nb_full && !take_b;

      if (!a_full_in && !na_fin) begin
         want_after = stm_pkg::WANT_A;
      end else if (!b_full_in && !nb_fin) begin
         want_after = stm_pkg::WANT_B;
      end else begin
         want_after = stm_pkg::WANT_NONE;
      end

      a_fin_in = na_fin;
      b_fin_in = nb_fin;
      if (want_after == stm_pkg::WANT_NONE) begin
         a_full_in = 1'b0;
         b_full_in = 1'b0;
         a_fin_in  = 1'b0;
         b_fin_in  = 1'b0;
      end
   end

   always_comb begin
      rsp_in = '0;
      if (want_now != {1'b0, rd.item.is_b}) begin
         rsp_in.want_next = want_now;
         rsp_in.error     = 1'b1;
      end else begin
         rsp_in.out_valid   = take_a || take_b;
         rsp_in.from_list_b = take_b;
         if (take_a) begin
            rsp_in.out_key     = a_key_in;
            rsp_in.out_payload = a_pay_in;
         end else if (take_b) begin
            rsp_in.out_key     = b_key_in;
            rsp_in.out_payload = b_pay_in;
         end
         rsp_in.want_next = want_after;
         rsp_in.done_res  = (want_after == stm_pkg::WANT_NONE);
      end
   end

   assign rsp_valid_in = pop || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_full_ff    <= 1'b0;
         b_full_ff    <= 1'b0;
         a_fin_ff     <= 1'b0;
         b_fin_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop && !rsp_in.error) begin
            a_full_ff <= a_full_in;
            b_full_ff <= b_full_in;
            a_fin_ff  <= a_fin_in;
            b_fin_ff  <= b_fin_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
         if (!rsp_in.error) begin
            a_key_ff <= a_key_in;
            a_pay_ff <= a_pay_in;
            b_key_ff <= b_key_in;
            b_pay_ff <= b_pay_in;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

[hw/rtl/sorted_tuple_merge_unit.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// sorted_tuple_merge_unit
// Two-way merge of two ascending tuple lists with one head per list.
// Path: an accepted request beat goes through a queue slot, then the
// response register. Throughput: one beat per cycle when rsp_stall is low,
// set by the single head compare in stm_back.
// Reset: synchronous; clears queue pointers, head flags and response valid.
// ---------------------------------------------------------------------------
module sorted_tuple_merge_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire stm_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output stm_pkg::rsp_type       rsp_data
);

   stm_pkg::push_type wr;
   stm_pkg::head_type rd;
   logic              queue_full;
   logic              pop;

   stm_front u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (queue_full),
      .wr         (wr)
   );

   stm_queue u_queue (
      .clock (clock),
      .reset (reset),
      .wr    (wr),
      .full  (queue_full),
      .pop   (pop),
      .rd    (rd)
   );

   stm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .rd        (rd),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

[tb/sv/sorted_tuple_merge_unit_tb.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// sorted_tuple_merge_unit_tb
// Self-checking bench for the two-way sorted tuple merge. A scoreboard keeps
// its own copy of both list heads, predicts one response beat per request
// beat and compares every response field. Stimulus is a short directed set
// (empty lists, key extremes, ties, one-sided pass-through, rejected beats)
// followed by random merges with random idling on both channels.
// ---------------------------------------------------------------------------
module sorted_tuple_merge_unit_tb;

   typedef logic signed [stm_pkg::KEY_BITS-1:0] key_type;

   class merge_scoreboard;
      key_type                          a_key, b_key;
      logic [stm_pkg::PAYLOAD_BITS-1:0] a_pay, b_pay;
      bit                               a_full, b_full, a_end, b_end;
      stm_pkg::rsp_type                 pending[$];
      int                               errors, merges, tuples, rejects;

      function void clear_heads();
         a_key  = '0;
         b_key  = '0;
         a_pay  = '0;
         b_pay  = '0;
         a_full = 1'b0;
         b_full = 1'b0;
         a_end  = 1'b0;
         b_end  = 1'b0;
      endfunction

      function new();
         clear_heads();
         errors  = 0;
         merges  = 0;
         tuples  = 0;
         rejects = 0;
      endfunction

      function logic [1:0] wanted();
         if (!a_full && !a_end) return stm_pkg::WANT_A;
         if (!b_full && !b_end) return stm_pkg::WANT_B;
         return stm_pkg::WANT_NONE;
      endfunction

      // predict the response for one accepted request beat
      function void note_request(stm_pkg::req_type beat);
         stm_pkg::rsp_type exp;
         logic [1:0]       w;
         w   = wanted();
         exp = '0;
         if (w != (beat.kind[0] ? stm_pkg::WANT_B : stm_pkg::WANT_A)) begin
            // beat from the list not asked for: dropped, state kept
            exp.want_next = w;
            exp.error     = 1'b1;
            rejects++;
         end else begin
            case (beat.kind)
               stm_pkg::KIND_A_ELEM: begin
                  a_key  = beat.key;
                  a_pay  = beat.payload;
                  a_full = 1'b1;
               end
               stm_pkg::KIND_B_ELEM: begin
                  b_key  = beat.key;
                  b_pay  = beat.payload;
                  b_full = 1'b1;
               end
               stm_pkg::KIND_A_END: a_end = 1'b1;
               default:             b_end = 1'b1;
            endcase
            // ties go to B
            if (a_full && (b_full ? (a_key < b_key) : b_end)) begin
               exp.out_valid   = 1'b1;
               exp.out_key     = a_key;
               exp.out_payload = a_pay;
               a_full          = 1'b0;
               tuples++;
            end else if (b_full && (a_full || a_end)) begin
               exp.out_valid   = 1'b1;
               exp.out_key     = b_key;
               exp.out_payload = b_pay;
               exp.from_list_b = 1'b1;
               b_full          = 1'b0;
               tuples++;
            end
            exp.want_next = wanted();
            if (exp.want_next == stm_pkg::WANT_NONE) begin
               exp.done_res = 1'b1;
               merges++;
               clear_heads();
            end
         end
         pending.push_back(exp);
      endfunction

      function void field_check(string name, logic [63:0] want, logic [63:0] seen);
         if (seen !== want) begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, seen);
            errors++;
         end
      endfunction

      function void check_response(stm_pkg::rsp_type got);
         stm_pkg::rsp_type exp;
         if (pending.size() == 0) begin
            $display("%0t: response beat with nothing expected: expected none, got %h",
                     $time, got);
            errors++;
            return;
         end
         exp = pending.pop_front();
         field_check("out_valid", 64'(exp.out_valid), 64'(got.out_valid));
         field_check("out_key", 64'(exp.out_key), 64'(got.out_key));
         field_check("out_payload", 64'(exp.out_payload), 64'(got.out_payload));
         field_check("from_list_b", 64'(exp.from_list_b), 64'(got.from_list_b));
         field_check("want_next", 64'(exp.want_next), 64'(got.want_next));
         field_check("done_res", 64'(exp.done_res), 64'(got.done_res));
         field_check("error", 64'(exp.error), 64'(got.error));
      endfunction
   endclass

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   stm_pkg::req_type req_data  = '0;
   logic             rsp_stall = 1'b0;
   logic             req_stall;
   logic             rsp_valid;
   stm_pkg::rsp_type rsp_data;

   merge_scoreboard sb;
   bit              quiet = 1'b0;
   int              list_beats = 0;
   int              stall_left = 0;

   sorted_tuple_merge_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // response side: random stall bursts, no new burst once the run goes quiet
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 15);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_response(rsp_data);
   end

   function automatic stm_pkg::req_type make_beat(logic [1:0] kind, key_type key,
                                                  logic [stm_pkg::PAYLOAD_BITS-1:0] pay);
      stm_pkg::req_type beat;
      beat.kind    = kind;
      beat.key     = key;
      beat.payload = pay;
      return beat;
   endfunction

   task automatic send_beat(input stm_pkg::req_type beat);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(beat);
   endtask

   function automatic key_type random_key(int style);
      key_type k;
      case (style)
         0: k = key_type'($urandom);
         1: k = key_type'($urandom_range(0, 8)) - key_type'(4);
         2: begin
            case ($urandom_range(0, 3))
               0: k = {1'b1, {(stm_pkg::KEY_BITS-1){1'b0}}};
               1: k = {1'b0, {(stm_pkg::KEY_BITS-1){1'b1}}};
               2: k = '0;
               default: k = '1;
            endcase
         end
         default: k = key_type'($urandom_range(0, 2000)) - key_type'(1000);
      endcase
      return k;
   endfunction

   task automatic run_directed();
      key_type kmin, kmax;
      kmin = {1'b1, {(stm_pkg::KEY_BITS-1){1'b0}}};
      kmax = {1'b0, {(stm_pkg::KEY_BITS-1){1'b1}}};
      // two empty lists
      send_beat(make_beat(stm_pkg::KIND_A_END, '0, '0));
      send_beat(make_beat(stm_pkg::KIND_B_END, '1, '1));
      // B beats while A is asked for
      send_beat(make_beat(stm_pkg::KIND_B_ELEM, kmax, 32'h1234_5678));
      send_beat(make_beat(stm_pkg::KIND_B_END, '0, '0));
      // key extremes, ties, then A passing through after B ends
      send_beat(make_beat(stm_pkg::KIND_A_ELEM, kmin, '0));
      send_beat(make_beat(stm_pkg::KIND_B_ELEM, kmax, '1));
      send_beat(make_beat(stm_pkg::KIND_A_ELEM, kmax, 32'hAAAA_AAAA));
      send_beat(make_beat(stm_pkg::KIND_B_ELEM, kmax, 32'h5555_5555));
      send_beat(make_beat(stm_pkg::KIND_B_END, '0, '0));
      send_beat(make_beat(stm_pkg::KIND_A_ELEM, '1, 32'hFFFF_0000));
      send_beat(make_beat(stm_pkg::KIND_A_END, '0, '0));
      // A beats while B is asked for, then a tie and A passing through after B ends
      send_beat(make_beat(stm_pkg::KIND_A_ELEM, '0, 32'h0000_FFFF));
      send_beat(make_beat(stm_pkg::KIND_A_ELEM, '1, '1));
      send_beat(make_beat(stm_pkg::KIND_A_END, '0, '0));
      send_beat(make_beat(stm_pkg::KIND_B_ELEM, '0, 32'h8000_0001));
      send_beat(make_beat(stm_pkg::KIND_B_END, '0, '0));
      send_beat(make_beat(stm_pkg::KIND_A_END, '0, '0));
      // A only, B empty
      send_beat(make_beat(stm_pkg::KIND_A_ELEM, 32'sd5, 32'h0F0F_0F0F));
      send_beat(make_beat(stm_pkg::KIND_B_END, '0, '0));
      send_beat(make_beat(stm_pkg::KIND_A_ELEM, 32'sd3, 32'hF0F0_F0F0));
      send_beat(make_beat(stm_pkg::KIND_A_END, '0, '0));
   endtask

   // one complete merge of two random lists, with some rejected beats mixed in
   task automatic run_one_merge();
      key_type    list_a[$], list_b[$];
      int         len_a, len_b, style, ia, ib, merges_at_start;
      logic [1:0] want_now;
      len_a = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
      len_b = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
      style = $urandom_range(0, 3);
      repeat (len_a) list_a.push_back(random_key(style));
      repeat (len_b) list_b.push_back(random_key(style));
      // most lists sorted; the rest exercise unordered input
      if ($urandom_range(0, 9) != 0) begin
         list_a.sort();
         list_b.sort();
      end
      ia = 0;
      ib = 0;
      merges_at_start = sb.merges;
      while (sb.merges == merges_at_start) begin
         quiet    = (list_beats >= 580);
         want_now = sb.wanted();
         if ($urandom_range(0, 9) == 0) begin
            if (want_now == stm_pkg::WANT_A)
               send_beat(make_beat($urandom_range(0, 1) ? stm_pkg::KIND_B_ELEM
                                                        : stm_pkg::KIND_B_END,
                                   key_type'($urandom), $urandom));
            else
               send_beat(make_beat($urandom_range(0, 1) ? stm_pkg::KIND_A_ELEM
                                                        : stm_pkg::KIND_A_END,
                                   key_type'($urandom), $urandom));
         end else if (want_now == stm_pkg::WANT_A) begin
            if (ia < list_a.size()) begin
               send_beat(make_beat(stm_pkg::KIND_A_ELEM, list_a[ia], $urandom));
               ia++;
            end else begin
               send_beat(make_beat(stm_pkg::KIND_A_END, key_type'($urandom), $urandom));
            end
            list_beats++;
         end else begin
            if (ib < list_b.size()) begin
               send_beat(make_beat(stm_pkg::KIND_B_ELEM, list_b[ib], $urandom));
               ib++;
            end else begin
               send_beat(make_beat(stm_pkg::KIND_B_END, key_type'($urandom), $urandom));
            end
            list_beats++;
         end
      end
   endtask

   initial begin
      #400000;
      $display("sorted_tuple_merge_unit_tb: errors");
      $finish;
   end

   initial begin
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      // rejected beats count toward the total sent
      while (list_beats + sb.rejects < 730) run_one_merge();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("merged %0d lists: %0d list beats, %0d tuples out, %0d rejected beats",
               sb.merges, list_beats, sb.tuples, sb.rejects);
      $display("mismatches seen: %0d", sb.errors);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("sorted_tuple_merge_unit_tb: clean");
      else
         $display("sorted_tuple_merge_unit_tb: errors");
      $finish;
   end

endmodule
`default_nettype wire
